// ----- rtl/ppe_pkg.sv -----
// Shared types, color constants and register indexes for the palette expander.
`default_nettype none

package ppe_pkg;

  typedef logic [23:0] pixel_t;

  localparam int NumPairs  = 4;
  localparam int NumPixels = 8;

  // Configuration register indexes
  localparam logic [7:0] RegPaletteSelect = 8'd0;
  localparam logic [7:0] RegColorMode     = 8'd1;
  localparam logic [7:0] RegGrayMode      = 8'd2;

  localparam pixel_t PxBlack   = 24'h000000;
  localparam pixel_t PxRed     = 24'hff0000;
  localparam pixel_t PxGreen   = 24'h00ff00;
  localparam pixel_t PxBlue    = 24'h0000ff;
  localparam pixel_t PxYellow  = 24'hffff00;
  localparam pixel_t PxCyan    = 24'h00ffff;
  localparam pixel_t PxMagenta = 24'hff00ff;
  localparam pixel_t PxWhite   = 24'hffffff;
  localparam pixel_t PxDkRed   = 24'haa0000;
  localparam pixel_t PxRdBrown = 24'h700000;
  localparam pixel_t PxViolet  = 24'haa00ff;
  localparam pixel_t PxVioBlue = 24'h7000ff;
  localparam pixel_t PxLtGreen = 24'h55ff00;
  localparam pixel_t PxLime    = 24'haaff00;
  localparam pixel_t PxGray1   = 24'h555555;
  localparam pixel_t PxGray2   = 24'ha9a9a9;

  localparam pixel_t PAL_ROM [0:15][0:3] = '{
    '{PxBlack, PxBlue,    PxGreen,   PxRed    },
    '{PxBlack, PxYellow,  PxMagenta, PxRed    },
    '{PxBlack, PxCyan,    PxBlue,    PxMagenta},
    '{PxBlack, PxGreen,   PxCyan,    PxYellow },
    '{PxBlack, PxMagenta, PxCyan,    PxWhite  },
    '{PxBlack, PxWhite,   PxWhite,   PxWhite  },
    '{PxBlack, PxDkRed,   PxRdBrown, PxRed    },
    '{PxBlack, PxLime,    PxLtGreen, PxYellow },
    '{PxBlack, PxViolet,  PxVioBlue, PxMagenta},
    '{PxBlack, PxLtGreen, PxVioBlue, PxRdBrown},
    '{PxBlack, PxLime,    PxViolet,  PxDkRed  },
    '{PxBlack, PxCyan,    PxYellow,  PxRed    },
    '{PxBlack, PxRed,     PxGreen,   PxCyan   },
    '{PxBlack, PxCyan,    PxYellow,  PxWhite  },
    '{PxBlack, PxYellow,  PxGreen,   PxWhite  },
    '{PxBlack, PxCyan,    PxGreen,   PxWhite  }
  };

  localparam pixel_t GRAY_ROM [0:3] = '{PxBlack, PxGray1, PxGray2, PxWhite};

  typedef struct packed {
    logic [3:0] palette_select;
    logic       color_mode;
    logic       gray_mode;
  } cfg_t;

  // Per-pair lookup results carried from the lookup stage to the select stage
  typedef struct packed {
    pixel_t     pal_color;
    pixel_t     gray_color;
    logic [1:0] bits;
  } lane_t;

endpackage

`default_nettype wire

// ----- rtl/packed_pixel_palette_expander.sv -----
// Top level of the packed pixel palette expander: three-stage pipeline.
//
// Usage:
//   Input channel (in_valid/in_ready, video_byte) takes one screen-memory
//   byte per item; the output channel (out_valid/out_ready, pixel_0..7)
//   gives eight 24-bit RGB pixels per item, pixel_0 from the low bits.
//   The configuration channel (cfg_valid/cfg_ready, cfg_addr, cfg_data)
//   writes palette_select (0), color_mode (1) and gray_mode (2); other
//   indexes are ignored. cfg_ready is always high. Write configuration
//   only while no item is in flight.
// Path: the input register loads on the input accept edge, then the
//   lookup register, then the output register, which sets out_valid.
// Throughput: one item per cycle while out_ready is high; each stage
//   loads if empty or if the next stage moves, so a full pipe has no bubbles.
// Reset: all valid bits clear, palette_select = 0, color_mode = 1,
//   gray_mode = 0.
// Stall: when out_ready is low the output register holds its item; the
//   stages behind it keep filling until all three hold an item, then
//   in_ready drops. Nothing is lost or repeated.
`default_nettype none

module packed_pixel_palette_expander (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_addr,
  input  wire logic [3:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         video_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ppe_pkg::pixel_t         pixel_0,
  output ppe_pkg::pixel_t         pixel_1,
  output ppe_pkg::pixel_t         pixel_2,
  output ppe_pkg::pixel_t         pixel_3,
  output ppe_pkg::pixel_t         pixel_4,
  output ppe_pkg::pixel_t         pixel_5,
  output ppe_pkg::pixel_t         pixel_6,
  output ppe_pkg::pixel_t         pixel_7
);
  import ppe_pkg::*;

  cfg_t cfg;

  // Stage 1: input byte register
  logic       s1_valid;
  logic [7:0] s1_byte;
  // Stage 2: per-pair lookup register
  logic                   s2_valid;
  lane_t [NumPairs-1:0]   s2_lanes;
  lane_t [NumPairs-1:0]   lanes_next;
  // Stage 3: output register
  pixel_t [NumPixels-1:0] pixels;
  pixel_t [NumPixels-1:0] pixels_next;

  logic s1_adv, s2_adv, s3_adv;

  ppe_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // A stage may load when it is empty or its item moves on this cycle.
  assign s3_adv   = !out_valid || out_ready;
  assign s2_adv   = !s2_valid  || s3_adv;
  assign s1_adv   = !s1_valid  || s2_adv;
  assign in_ready = s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_byte <= video_byte;
    end
  end

  for (genvar n = 0; n < NumPairs; n++) begin : g_lane
    ppe_pair_lookup u_lookup (
      .pair           (s1_byte[2*n +: 2]),
      .palette_select (cfg.palette_select),
      .lane           (lanes_next[n])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid) begin
      s2_lanes <= lanes_next;
    end
  end

  ppe_pixel_select u_select (
    .cfg    (cfg),
    .lanes  (s2_lanes),
    .pixels (pixels_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_adv) begin
      out_valid <= s2_valid;
    end
  end

  // Hold the output item while the receiver stalls.
  always_ff @(posedge clk) begin
    if (s3_adv && s2_valid) begin
      pixels <= pixels_next;
    end
  end

  assign pixel_0 = pixels[0];
  assign pixel_1 = pixels[1];
  assign pixel_2 = pixels[2];
  assign pixel_3 = pixels[3];
  assign pixel_4 = pixels[4];
  assign pixel_5 = pixels[5];
  assign pixel_6 = pixels[6];
  assign pixel_7 = pixels[7];

  // Input back-pressure only when every stage holds an item.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && s2_valid && out_valid))
    else $error("in_ready low with an empty stage");

  // An accepted item always lands in stage 1.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> s1_valid)
    else $error("accepted item lost at stage 1");

  // Plain monochrome gives only black or white.
  a_mono_levels: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !cfg.color_mode && !cfg.gray_mode) |->
      ((pixel_0 == PxBlack || pixel_0 == PxWhite) &&
       (pixel_7 == PxBlack || pixel_7 == PxWhite)))
    else $error("monochrome pixel not black or white");

endmodule

`default_nettype wire

// ----- rtl/ppe_cfg_regs.sv -----
// Configuration register file for the palette expander.
`default_nettype none

module ppe_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_addr,
  input  wire logic [3:0]  cfg_data,
  output ppe_pkg::cfg_t    cfg
);
  import ppe_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.palette_select <= 4'd0;
      cfg.color_mode     <= 1'b1;
      cfg.gray_mode      <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_addr)
        RegPaletteSelect: cfg.palette_select <= cfg_data;
        RegColorMode:     cfg.color_mode     <= cfg_data[0];
        RegGrayMode:      cfg.gray_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ppe_pair_lookup.sv -----
// Table lookup of palette color and gray level for one 2-bit pair.
`default_nettype none

module ppe_pair_lookup (
  input  wire logic [1:0]  pair,
  input  wire logic [3:0]  palette_select,
  output ppe_pkg::lane_t   lane
);
  import ppe_pkg::*;

  always_comb begin
    lane.pal_color  = PAL_ROM[palette_select][pair];
    lane.gray_color = GRAY_ROM[pair];
    lane.bits       = pair;
  end

endmodule

`default_nettype wire

// ----- rtl/ppe_pixel_select.sv -----
// Mode selection that turns four pair lookups into eight pixels.
`default_nettype none

module ppe_pixel_select (
  input  ppe_pkg::cfg_t                             cfg,
  input  ppe_pkg::lane_t [ppe_pkg::NumPairs-1:0]    lanes,
  output ppe_pkg::pixel_t [ppe_pkg::NumPixels-1:0]  pixels
);
  import ppe_pkg::*;

  always_comb begin
    for (int n = 0; n < NumPairs; n++) begin
      if (cfg.color_mode) begin
        pixels[2*n]   = lanes[n].pal_color;
        pixels[2*n+1] = lanes[n].pal_color;
      end else if (cfg.gray_mode) begin
        pixels[2*n]   = lanes[n].gray_color;
        pixels[2*n+1] = lanes[n].gray_color;
      end else begin
        pixels[2*n]   = lanes[n].bits[0] ? PxWhite : PxBlack;
        pixels[2*n+1] = lanes[n].bits[1] ? PxWhite : PxBlack;
      end
    end
  end

endmodule

`default_nettype wire
